[hdl/bfdh_pkg.sv]
// Types, constants and codes shared by the Bloom filter core.
`timescale 1ns / 1ps
package bfdh_pkg;

   localparam int unsigned MAX_BITS   = 65536;
   localparam int unsigned MAX_PROBES = 32;
   localparam int unsigned WORD_COUNT = MAX_BITS / 64;
   localparam int unsigned ADDR_W     = $clog2(WORD_COUNT);

   localparam logic [63:0] SEED_ONE  = 64'h243f6a8885a308d3;
   localparam logic [63:0] SEED_TWO  = 64'hb7e151628aed2a6b;
   localparam logic [63:0] MIX_ADD   = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;

   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_QUERY = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;
   localparam logic [1:0] ACT_SPARE = 2'd3;

   localparam logic CSR_FILT_SIZE  = 1'b0;
   localparam logic CSR_HASH_COUNT = 1'b1;

   localparam logic [1:0] DIV_H1  = 2'd0;
   localparam logic [1:0] DIV_H2  = 2'd1;
   localparam logic [1:0] DIV_TOP = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] key;
   } req_word_type;

   typedef struct packed {
      logic        maybe_present;
      logic [31:0] insert_count;
   } rsp_word_type;

   typedef enum logic [4:0] {
      ST_INIT, ST_IDLE, ST_DISP, ST_CLR, ST_HINIT, ST_HM0, ST_HM1, ST_HM2, ST_HXF,
      ST_DLOAD, ST_DRUN, ST_DSTORE, ST_PSTART, ST_PRD, ST_PCHK, ST_FIN, ST_RESP
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE, CMD_LOAD, CMD_CLR, CMD_HINIT, CMD_M0, CMD_M1, CMD_M2, CMD_HXF,
      CMD_DLOAD, CMD_DRUN, CMD_DSTORE, CMD_PSTART, CMD_PRD, CMD_PCHK, CMD_FIN
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type        op;
      logic              hsel;
      logic              midx;
      logic [1:0]        dsel;
      logic [ADDR_W-1:0] addr;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       n_zero;
      logic [5:0] probes;
   } status_type;

endpackage

[hdl/bfdh_ctrl.sv]
// Sequencer for the Bloom filter core: hashing, reduction, probe walk and clearing.
`timescale 1ns / 1ps
module bfdh_ctrl
   import bfdh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [9:0] cnt_ff, cnt_in;
   logic       hsel_ff, hsel_in;
   logic       midx_ff, midx_in;
   logic [1:0] dsel_ff, dsel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         cnt_ff   <= '0;
         hsel_ff  <= 1'b0;
         midx_ff  <= 1'b0;
         dsel_ff  <= DIV_H1;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         hsel_ff  <= hsel_in;
         midx_ff  <= midx_in;
         dsel_ff  <= dsel_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      hsel_in  = hsel_ff;
      midx_in  = midx_ff;
      dsel_in  = dsel_ff;
      unique case (state_ff)
         ST_INIT: begin
            cnt_in = cnt_ff + 10'd1;
            if (cnt_ff == 10'(WORD_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            cnt_in  = '0;
            hsel_in = 1'b0;
            midx_in = 1'b0;
            if (status.action == ACT_CLEAR) begin
               state_in = ST_CLR;
            end else if ((status.action == ACT_ADD || status.action == ACT_QUERY)
                         && !status.n_zero && status.probes != 6'd0) begin
               state_in = ST_HINIT;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_CLR: begin
            cnt_in = cnt_ff + 10'd1;
            if (cnt_ff == 10'(WORD_COUNT - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_HINIT: state_in = ST_HM0;
         ST_HM0:   state_in = ST_HM1;
         ST_HM1:   state_in = ST_HM2;
         ST_HM2:   state_in = ST_HXF;
         ST_HXF: begin
            if (!midx_ff) begin
               midx_in  = 1'b1;
               state_in = ST_HM0;
            end else if (!hsel_ff) begin
               hsel_in  = 1'b1;
               midx_in  = 1'b0;
               state_in = ST_HINIT;
            end else begin
               dsel_in  = DIV_H1;
               state_in = ST_DLOAD;
            end
         end
         ST_DLOAD: begin
            cnt_in   = '0;
            state_in = ST_DRUN;
         end
         ST_DRUN: begin
            cnt_in = cnt_ff + 10'd1;
            if (cnt_ff[4:0] == 5'd31) begin
               state_in = ST_DSTORE;
            end
         end
         ST_DSTORE: begin
            if (dsel_ff == DIV_TOP) begin
               state_in = ST_PSTART;
            end else begin
               dsel_in  = dsel_ff + 2'd1;
               state_in = ST_DLOAD;
            end
         end
         ST_PSTART: begin
            cnt_in   = '0;
            state_in = ST_PRD;
         end
         ST_PRD: state_in = ST_PCHK;
         ST_PCHK: begin
            cnt_in = cnt_ff + 10'd1;
            if (cnt_ff[5:0] + 6'd1 == status.probes) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_PRD;
            end
         end
         ST_FIN: state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      cmd.op    = CMD_NONE;
      cmd.hsel  = hsel_ff;
      cmd.midx  = midx_ff;
      cmd.dsel  = dsel_ff;
      cmd.addr  = cnt_ff[ADDR_W-1:0];
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_INIT:   cmd.op = CMD_CLR;
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.op    = CMD_LOAD;
         end
         ST_DISP:   cmd.op = CMD_NONE;
         ST_CLR:    cmd.op = CMD_CLR;
         ST_HINIT:  cmd.op = CMD_HINIT;
         ST_HM0:    cmd.op = CMD_M0;
         ST_HM1:    cmd.op = CMD_M1;
         ST_HM2:    cmd.op = CMD_M2;
         ST_HXF:    cmd.op = CMD_HXF;
         ST_DLOAD:  cmd.op = CMD_DLOAD;
         ST_DRUN:   cmd.op = CMD_DRUN;
         ST_DSTORE: cmd.op = CMD_DSTORE;
         ST_PSTART: cmd.op = CMD_PSTART;
         ST_PRD:    cmd.op = CMD_PRD;
         ST_PCHK:   cmd.op = CMD_PCHK;
         ST_FIN:    cmd.op = CMD_FIN;
         ST_RESP:   rsp_valid = 1'b1;
         default:   cmd.op = CMD_NONE;
      endcase
   end

endmodule

[hdl/bfdh_dp.sv]
// Datapath of the Bloom filter core: hash mixer, remainder unit, bit array and counters.
`timescale 1ns / 1ps
module bfdh_dp
   import bfdh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  req_word_type req_data,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [16:0]  csr_wdata,
   input  cmd_type      cmd,
   output status_type   status,
   output rsp_word_type rsp_data
);

   logic [63:0] mem [WORD_COUNT];
   logic [63:0] rdata_ff;

   logic [16:0] filt_size_ff;
   logic [5:0]  hash_count_ff;
   logic [31:0] count_ff;
   logic        maybe_ff;

   logic [1:0]  act_ff;
   logic [63:0] key_ff;
   logic [63:0] t_ff, acc_ff, h1_ff, h2_ff, pos_ff, dvd_ff;
   logic [16:0] rem_ff, b_ff, s_ff, r_ff;
   logic        miss_ff;

   logic [16:0] n_live;
   logic [63:0] seed, v_init, mul_c, prod, h_out;
   logic [31:0] mul_a, mul_b;
   logic [17:0] r0, r1, r2, rp1;
   logic [64:0] pos_sum;
   logic [17:0] s_a, s_b, s_c;
   logic [63:0] mask;

   assign n_live = (filt_size_ff > 17'(MAX_BITS)) ? 17'(MAX_BITS) : filt_size_ff;
   assign status.action = act_ff;
   assign status.n_zero = (n_live == 17'd0);
   assign status.probes = (hash_count_ff > 6'(MAX_PROBES)) ? 6'(MAX_PROBES) : hash_count_ff;
   assign rsp_data.maybe_present = maybe_ff;
   assign rsp_data.insert_count  = count_ff;

   // 64x64 low product taken as three 32x32 partial products
   assign seed   = cmd.hsel ? SEED_TWO : SEED_ONE;
   assign v_init = (key_ff ^ seed) + MIX_ADD;
   assign mul_c  = cmd.midx ? MIX_MUL_B : MIX_MUL_A;
   assign mul_a  = (cmd.op == CMD_M2) ? t_ff[63:32] : t_ff[31:0];
   assign mul_b  = (cmd.op == CMD_M1) ? mul_c[63:32] : mul_c[31:0];
   assign prod   = 64'(mul_a) * 64'(mul_b);
   assign h_out  = acc_ff ^ (acc_ff >> 31);

   // two restoring steps per cycle
   always_comb begin
      r0 = {1'b0, rem_ff};
      r1 = {r0[16:0], dvd_ff[63]};
      if (r1 >= {1'b0, n_live}) begin
         r1 = r1 - {1'b0, n_live};
      end
      r2 = {r1[16:0], dvd_ff[62]};
      if (r2 >= {1'b0, n_live}) begin
         r2 = r2 - {1'b0, n_live};
      end
   end

   assign rp1 = {1'b0, rem_ff} + 18'd1;

   // next probe position modulo n; a wrap of the 64-bit sum takes off 2^64 mod n
   always_comb begin
      pos_sum = {1'b0, pos_ff} + {1'b0, h2_ff};
      s_a = {1'b0, b_ff} + {1'b0, s_ff};
      if (s_a >= {1'b0, n_live}) begin
         s_a = s_a - {1'b0, n_live};
      end
      s_b = s_a;
      if (pos_sum[64]) begin
         if (s_a >= {1'b0, r_ff}) begin
            s_b = s_a - {1'b0, r_ff};
         end else begin
            s_b = s_a + {1'b0, n_live} - {1'b0, r_ff};
         end
      end
      s_c = s_b;
   end

   assign mask = 64'd1 << b_ff[5:0];

   always_ff @(posedge clock) begin
      if (cmd.op == CMD_CLR) begin
         mem[cmd.addr] <= '0;
      end else if (cmd.op == CMD_PCHK && act_ff == ACT_ADD) begin
         mem[b_ff[ADDR_W+5:6]] <= rdata_ff | mask;
      end
      if (cmd.op == CMD_PRD) begin
         rdata_ff <= mem[b_ff[ADDR_W+5:6]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filt_size_ff  <= 17'(MAX_BITS);
         hash_count_ff <= 6'd7;
         count_ff      <= '0;
         maybe_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_FILT_SIZE) begin
               filt_size_ff <= csr_wdata;
            end else begin
               hash_count_ff <= csr_wdata[5:0];
            end
         end
         if (cmd.op == CMD_FIN) begin
            maybe_ff <= (act_ff == ACT_QUERY) && !status.n_zero && !miss_ff;
            if (act_ff == ACT_CLEAR) begin
               count_ff <= '0;
            end else if (act_ff == ACT_ADD && !status.n_zero && count_ff != 32'hFFFFFFFF) begin
               count_ff <= count_ff + 32'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         CMD_LOAD: begin
            act_ff  <= req_data.action;
            key_ff  <= req_data.key;
            miss_ff <= 1'b0;
         end
         CMD_HINIT: t_ff <= v_init ^ (v_init >> 30);
         CMD_M0:    acc_ff <= prod;
         CMD_M1, CMD_M2: acc_ff <= acc_ff + {prod[31:0], 32'd0};
         CMD_HXF: begin
            if (!cmd.midx) begin
               t_ff <= acc_ff ^ (acc_ff >> 27);
            end else if (cmd.hsel) begin
               h2_ff <= h_out | 64'd1;
            end else begin
               h1_ff <= h_out;
            end
         end
         CMD_DLOAD: begin
            rem_ff <= '0;
            case (cmd.dsel)
               DIV_H1:  dvd_ff <= h1_ff;
               DIV_H2:  dvd_ff <= h2_ff;
               default: dvd_ff <= '1;
            endcase
         end
         CMD_DRUN: begin
            rem_ff <= r2[16:0];
            dvd_ff <= {dvd_ff[61:0], 2'b00};
         end
         CMD_DSTORE: begin
            case (cmd.dsel)
               DIV_H1:  b_ff <= rem_ff;
               DIV_H2:  s_ff <= rem_ff;
               default: r_ff <= (rp1 == {1'b0, n_live}) ? 17'd0 : rp1[16:0];
            endcase
         end
         CMD_PSTART: pos_ff <= h1_ff;
         CMD_PCHK: begin
            if (act_ff == ACT_QUERY && (rdata_ff & mask) == 64'd0) begin
               miss_ff <= 1'b1;
            end
            pos_ff <= pos_sum[63:0];
            b_ff   <= s_c[16:0];
         end
         default: ;
      endcase
   end

endmodule

[hdl/bloom_filter_double_hash_core.sv]
// Add/query: hash with both seeds, three reductions, then a read and an update per probe.
// Disabled words, zero probes and the spare action skip to finish; clear sweeps the bit array.
// Hashing runs on one shared 32x32 multiplier; reduction is a 2-bit-per-cycle remainder unit.
// Each probe is a read, then an update, on the single-port bit array.
// One word at a time: the next request is taken once the response has been taken.
// Reset is synchronous; afterwards a sweep zeroes the bit array with req_stall high.
`timescale 1ns / 1ps
module bloom_filter_double_hash_core
   import bfdh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [16:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   bfdh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bfdh_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

[hdl/bfdh_checker.sv]
// Port-level checks for the Bloom filter core, bound to the top level.
`timescale 1ns / 1ps
module bfdh_checker
   import bfdh_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   a_init_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken during clearing sweep");

   a_one_word: assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("request taken while response pending");

   a_no_bypass: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid)
      else $error("response in the cycle after request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind bloom_filter_double_hash_core bfdh_checker u_bfdh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[test/tb_bloom_filter_double_hash_core.sv]
// Self-checking testbench for the double-hash Bloom filter core.
`timescale 1ns / 1ps
module tb_bloom_filter_double_hash_core;
   import bfdh_pkg::*;

   class bloom_scoreboard;
      logic [63:0]  filt_bits [0:WORD_COUNT-1];
      logic [31:0]  adds_seen;
      logic [16:0]  filt_size;
      logic [5:0]   hash_count;
      rsp_word_type pending_rsp [$];
      int           mismatches;
      int           rsp_checked;
      int           hits_seen;

      function new();
         for (int w = 0; w < WORD_COUNT; w++) filt_bits[w] = '0;
         adds_seen  = '0;
         filt_size  = 17'd65536;
         hash_count = 6'd7;
         mismatches = 0;
         rsp_checked = 0;
         hits_seen = 0;
      endfunction

      function logic [63:0] splitmix(logic [63:0] v);
         v = v + MIX_ADD;
         v = (v ^ (v >> 30)) * MIX_MUL_A;
         v = (v ^ (v >> 27)) * MIX_MUL_B;
         return v ^ (v >> 31);
      endfunction

      function logic probe_walk(logic [63:0] key, logic set_bits);
         logic [63:0] nbits, pos, stride, b;
         int probes;
         nbits  = (filt_size > MAX_BITS) ? 64'(MAX_BITS) : 64'(filt_size);
         probes = (hash_count > MAX_PROBES) ? MAX_PROBES : hash_count;
         pos    = splitmix(key ^ SEED_ONE);
         stride = splitmix(key ^ SEED_TWO) | 64'd1;
         for (int i = 0; i < probes; i++) begin
            b = pos % nbits;
            if (set_bits) filt_bits[b >> 6][b[5:0]] = 1'b1;
            else if (!filt_bits[b >> 6][b[5:0]]) return 1'b0;
            pos = pos + stride;
         end
         return 1'b1;
      endfunction

      function void note_req(req_word_type r);
         rsp_word_type e;
         logic live;
         e.maybe_present = 1'b0;
         live = (filt_size != 0);
         case (r.action)
            ACT_ADD: begin
               if (live) begin
                  void'(probe_walk(r.key, 1'b1));
                  if (adds_seen != 32'hFFFF_FFFF) adds_seen++;
               end
            end
            ACT_QUERY: begin
               if (live) e.maybe_present = probe_walk(r.key, 1'b0);
            end
            ACT_CLEAR: begin
               for (int w = 0; w < WORD_COUNT; w++) filt_bits[w] = '0;
               adds_seen = '0;
            end
            default: ;
         endcase
         e.insert_count = adds_seen;
         pending_rsp.push_back(e);
      endfunction

      function void check_rsp(rsp_word_type got);
         rsp_word_type e;
         rsp_checked++;
         if (got.maybe_present) hits_seen++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp word %h", got);
            return;
         end
         e = pending_rsp.pop_front();
         if (got.maybe_present !== e.maybe_present || got.insert_count !== e.insert_count) begin
            mismatches++;
            if (mismatches <= 10)
               $display("rsp mismatch: exp present=%b count=%h got present=%b count=%h",
                        e.maybe_present, e.insert_count, got.maybe_present, got.insert_count);
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_we = 1'b0;
   logic         csr_index = 1'b0;
   logic [16:0]  csr_wdata = '0;

   bloom_scoreboard filt_sb = new();
   logic [63:0] key_pool [0:63];
   int  hold_off = 0;
   int  idle_cycles = 0;
   int  words_sent = 0;
   bit  timed_out = 1'b0;

   localparam int IDLE_LIMIT = 20000;

   always #2 clock = ~clock;

   bloom_filter_double_hash_core u_dut (.*);

   // receiver: own stall pattern, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off > 0) begin
         rsp_stall <= 1'b1;
         hold_off <= hold_off - 1;
      end else begin
         case ($urandom_range(0, 3))
            0: rsp_stall <= ($urandom_range(0, 1) == 1);
            1: rsp_stall <= ($urandom_range(0, 7) == 0);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) filt_sb.check_rsp(rsp_data);
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("watchdog: no word accepted for %0d cycles", IDLE_LIMIT);
         $display("[bloom_filter_double_hash_core] ERROR");
         $finish;
      end
   end

   task automatic send_word(logic [1:0] action, logic [63:0] key);
      req_word_type r;
      r.action = action;
      r.key    = key;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      filt_sb.note_req(r);
      words_sent++;
   endtask

   task automatic go_idle(int gap);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (filt_sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [16:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FILT_SIZE) filt_sb.filt_size = val;
      else filt_sb.hash_count = val[5:0];
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic random_phase(int n, int add_pct, int pool_pct);
      logic [1:0]  act;
      logic [63:0] key;
      int burst;
      while (n > 0) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && n > 0) begin
            if ($urandom_range(0, 99) < 2) act = ($urandom_range(0, 1) == 1) ? ACT_SPARE : ACT_CLEAR;
            else act = ($urandom_range(0, 99) < add_pct) ? ACT_ADD : ACT_QUERY;
            key = ($urandom_range(0, 99) < pool_pct) ? key_pool[$urandom_range(0, 63)] : rand64();
            send_word(act, key);
            burst--;
            n--;
         end
         if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 30));
      end
   endtask

   initial begin
      for (int i = 0; i < 64; i++) key_pool[i] = rand64();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes and every action at reset settings
      send_word(ACT_QUERY, 64'd0);
      send_word(ACT_ADD, 64'd0);
      send_word(ACT_QUERY, 64'd0);
      send_word(ACT_ADD, '1);
      send_word(ACT_QUERY, '1);
      send_word(ACT_QUERY, 64'h5555_5555_5555_5555);
      send_word(ACT_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
      send_word(ACT_SPARE, '1);
      send_word(ACT_QUERY, 64'hAAAA_AAAA_AAAA_AAAA);
      send_word(ACT_CLEAR, '1);
      send_word(ACT_QUERY, '1);
      drain();
      // disabled filter
      write_csr(CSR_FILT_SIZE, 17'd0);
      send_word(ACT_ADD, 64'd1);
      send_word(ACT_QUERY, 64'd1);
      drain();
      // zero and oversized probe count, oversized bit count
      write_csr(CSR_FILT_SIZE, 17'h1FFFF);
      write_csr(CSR_HASH_COUNT, 17'd0);
      send_word(ACT_ADD, 64'd2);
      send_word(ACT_QUERY, 64'd3);
      drain();
      write_csr(CSR_HASH_COUNT, 17'h1FFFF);
      send_word(ACT_ADD, 64'd4);
      send_word(ACT_QUERY, 64'd4);
      drain();
      // shrink: bits beyond new size kept
      write_csr(CSR_FILT_SIZE, 17'd1);
      write_csr(CSR_HASH_COUNT, 17'd1);
      send_word(ACT_QUERY, 64'd9);
      send_word(ACT_ADD, 64'd9);
      send_word(ACT_QUERY, 64'd7);
      drain();

      // long receiver hold-off while sender keeps offering
      write_csr(CSR_FILT_SIZE, 17'd65536);
      write_csr(CSR_HASH_COUNT, 17'd7);
      hold_off = 600;
      random_phase(30, 50, 50);
      drain();

      write_csr(CSR_FILT_SIZE, 17'd64);
      write_csr(CSR_HASH_COUNT, 17'd3);
      random_phase(250, 40, 70);
      drain();
      write_csr(CSR_FILT_SIZE, 17'd1000);
      write_csr(CSR_HASH_COUNT, 17'd32);
      random_phase(250, 50, 70);
      drain();
      write_csr(CSR_FILT_SIZE, 17'd65535);
      write_csr(CSR_HASH_COUNT, 17'd1);
      random_phase(250, 50, 60);
      drain();
      write_csr(CSR_FILT_SIZE, 17'd0);
      write_csr(CSR_HASH_COUNT, 17'd5);
      random_phase(50, 50, 50);
      drain();
      write_csr(CSR_FILT_SIZE, 17'($urandom_range(1, 131071)));
      write_csr(CSR_HASH_COUNT, 17'($urandom_range(0, 63)));
      random_phase(300, 50, 60);
      drain();
      write_csr(CSR_FILT_SIZE, 17'd4096);
      write_csr(CSR_HASH_COUNT, 17'd7);
      random_phase(300, 50, 60);
      drain();
      write_csr(CSR_FILT_SIZE, 17'd200);
      write_csr(CSR_HASH_COUNT, 17'd4);
      random_phase(300, 50, 60);
      drain();

      $display("covered %0d words, %0d responses, %0d hits, sizes from 0 to 65536 bits",
               words_sent, filt_sb.rsp_checked, filt_sb.hits_seen);
      $display("probe counts 0 to 63, saturation of sizes and unused action exercised");
      if (filt_sb.mismatches == 0 && filt_sb.pending_rsp.size() == 0) begin
         $display("[bloom_filter_double_hash_core] OK");
      end else begin
         $display("%0d mismatches, %0d responses outstanding", filt_sb.mismatches,
                  filt_sb.pending_rsp.size());
         $display("[bloom_filter_double_hash_core] ERROR");
      end
      $finish;
   end
endmodule
